>>> hw/rtl/uds_pkg.sv
// Shared types and constants for the URI dot segment remover.
package uds_pkg;

	localparam int PATH_DEPTH_DEF = 64;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} in_t;

	typedef struct packed {
		logic [7:0] ch_out;
		logic       is_last;
		logic       is_empty;
		logic       overflow;
	} out_t;

endpackage

>>> hw/rtl/uri_dot_segment_remover.sv
// Top level of the URI dot segment remover: path store, sequencer and result register.
//
//   channel | direction | handshake               | payload
//   item    | in        | item_valid / item_ready | item   (uds_pkg::in_t)
//   res     | out       | res_valid  / res_ready  | res    (uds_pkg::out_t)
//
// An ordinary character, and a slash or dot that removes nothing, is handled in the idle state.
// A slash or path end that removes segments walks back over the store, reading and then
// comparing each removed character (one read port, registered read), and then appends a slash.
// The end beat emits the path, reading and then loading each character, while res_ready is high;
// res_ready low holds the sequencer. item_ready is high only when the sequencer is idle.
// Reset clears the control state at once; the store needs no clearing pass.
module uri_dot_segment_remover #(
	parameter int PATH_DEPTH = uds_pkg::PATH_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  uds_pkg::in_t  item,
	output logic          res_valid,
	input  logic          res_ready,
	output uds_pkg::out_t res
);
	import uds_pkg::*;

	localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int PW = $clog2(PATH_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_FIN,
		ST_EMIT_START,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t        state_q;
	logic [PW-1:0] pos_q;
	logic [1:0]    run_q;
	logic          after_slash_q;
	logic          dropped_q;
	logic [1:0]    cnt_q;
	logic          end_q;
	logic [AW-1:0] idx_q;
	logic          res_valid_q;
	out_t          res_q;

	logic          accept;
	logic          room;
	logic          run_walks;
	logic          out_free;
	logic          res_load;
	logic [PW-1:0] pos_m1;
	logic          is_last;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign room       = (pos_q < PW'(PATH_DEPTH));
	assign run_walks  = (run_q == 2'd1) || (run_q == 2'd2);
	assign out_free   = !res_valid_q || res_ready;
	// A result beat is loaded for the empty marker or for each stored character.
	assign res_load   = out_free && ((state_q == ST_EMIT_START && pos_q == '0) ||
	                                 state_q == ST_EMIT_LD);
	assign pos_m1     = pos_q - PW'(1);
	assign is_last    = ((PW'(idx_q) + PW'(1)) == pos_q);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = item.ch;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				// Every character beat stores its byte while there is room, except a slash that first walks back.
				if (accept && item.kind == KIND_CHAR && room &&
				    !(item.ch == CH_SLASH && run_walks)) begin
					ram_we = 1'b1;
				end
			end
			ST_WALK_RD: begin
				ram_re    = (pos_q != '0);
				ram_raddr = pos_m1[AW-1:0];
			end
			ST_FIN: begin
				ram_we    = room;
				ram_wdata = CH_SLASH;
			end
			ST_EMIT_RD: begin
				ram_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	uds_ram #(
		.WIDTH(8),
		.DEPTH(PATH_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			run_q         <= '0;
			after_slash_q <= 1'b1;
			dropped_q     <= 1'b0;
			cnt_q         <= '0;
			end_q         <= 1'b0;
			idx_q         <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_END) begin
							end_q <= 1'b1;
							if (after_slash_q && run_walks) begin
								cnt_q   <= run_q;
								state_q <= ST_WALK_RD;
							end else begin
								state_q <= ST_EMIT_START;
							end
						end else if (item.ch == CH_SLASH) begin
							run_q         <= '0;
							after_slash_q <= 1'b1;
							if (run_walks) begin
								cnt_q   <= run_q;
								end_q   <= 1'b0;
								state_q <= ST_WALK_RD;
							end else if (room) begin
								pos_q <= pos_q + PW'(1);
							end else begin
								dropped_q <= 1'b1;
							end
						end else begin
							if (room) begin
								pos_q <= pos_q + PW'(1);
							end else begin
								dropped_q <= 1'b1;
							end
							if (item.ch == CH_DOT) begin
								if (after_slash_q && run_q != 2'd3) begin
									run_q <= run_q + 2'd1;
								end
							end else begin
								run_q         <= '0;
								after_slash_q <= 1'b0;
							end
						end
					end
				end
				ST_WALK_RD: begin
					if (pos_q == '0) begin
						// Nothing left to remove; this segment step is finished.
						cnt_q   <= cnt_q - 2'd1;
						state_q <= (cnt_q == 2'd1) ? ST_FIN : ST_WALK_RD;
					end else begin
						state_q <= ST_WALK_CMP;
					end
				end
				ST_WALK_CMP: begin
					pos_q <= pos_m1;
					if (ram_rdata == CH_SLASH) begin
						cnt_q   <= cnt_q - 2'd1;
						state_q <= (cnt_q == 2'd1) ? ST_FIN : ST_WALK_RD;
					end else begin
						state_q <= ST_WALK_RD;
					end
				end
				ST_FIN: begin
					if (room) begin
						pos_q <= pos_q + PW'(1);
					end else begin
						dropped_q <= 1'b1;
					end
					state_q <= end_q ? ST_EMIT_START : ST_IDLE;
				end
				ST_EMIT_START: begin
					if (pos_q != '0) begin
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
					end else if (out_free) begin
						res_q.ch_out      <= '0;
						res_q.is_last     <= 1'b1;
						res_q.is_empty    <= 1'b1;
						res_q.overflow    <= dropped_q;
						run_q             <= '0;
						after_slash_q     <= 1'b1;
						dropped_q         <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						res_q.ch_out   <= ram_rdata;
						res_q.is_last  <= is_last;
						res_q.is_empty <= 1'b0;
						res_q.overflow <= dropped_q;
						if (is_last) begin
							pos_q         <= '0;
							run_q         <= '0;
							after_slash_q <= 1'b1;
							dropped_q     <= 1'b0;
							state_q       <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The write position never runs past the store.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(PATH_DEPTH))
		else $error("write position beyond store depth");

	// A store write only happens while there is room.
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> room)
		else $error("store write with no room");

	// A walk always has at least one segment left to remove.
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_RD || state_q == ST_WALK_CMP) |-> cnt_q != 2'd0)
		else $error("walk-back with zero segment count");

	// The empty marker is a single last beat with a zero character.
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.is_empty) |-> (res_q.is_last && res_q.ch_out == 8'h00))
		else $error("malformed empty marker");

	// Emission only starts after the end beat has been taken.
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_LD) |-> end_q)
		else $error("emission without an end beat");

endmodule

>>> hw/rtl/uds_ram.sv
// Generic single write port, single read port RAM with registered read data.
module uds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
